### rtl/glr_pkg.sv
// Package with shared constants and the job type of the line rasterizer.
package glr_pkg;

  localparam int unsigned WIN_W_DEF = 1024;
  localparam int unsigned WIN_H_DEF = 1024;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic STATUS_PIXEL = 1'b0;
  localparam logic STATUS_ABORT = 1'b1;

  // One pixel job handed from the stepper to the color stage.
  typedef struct packed {
    logic        abort;
    logic        last;
    logic [10:0] px;
    logic [10:0] py;
    logic [23:0] c1;
    logic [23:0] c2;
    logic [12:0] num;
    logic [12:0] den;
  } glr_job_t;

endpackage

### rtl/glr_stepper.sv
// Front part: accepts load and step transfers, holds the line state and issues pixel jobs.
module glr_stepper #(
  parameter int unsigned WIN_W = glr_pkg::WIN_W_DEF,
  parameter int unsigned WIN_H = glr_pkg::WIN_H_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic signed [11:0] in_x_start,
  input  logic signed [11:0] in_y_start,
  input  logic signed [11:0] in_x_end,
  input  logic signed [11:0] in_y_end,
  input  logic [23:0]        in_color_start,
  input  logic [23:0]        in_color_end,
  output logic               job_valid,
  input  logic               job_stall,
  output glr_pkg::glr_job_t  job
);

  localparam logic signed [13:0] WW = 14'(WIN_W);
  localparam logic signed [13:0] WH = 14'(WIN_H);

  logic               active_r;
  logic signed [11:0] cur_x_r, cur_y_r, stop_x_r, stop_y_r, org_x_r, org_y_r;
  logic signed [13:0] dx_r, dy_r, err_r;
  logic               sx_r, sy_r;
  logic [23:0]        c1_r, c2_r;

  logic               take;
  logic signed [13:0] dxl, dyl, maj, nerr;
  logic signed [13:0] ncx, ncy;
  logic               inside_ok, xmajor;

  function automatic logic in_win(input logic signed [11:0] x, input logic signed [11:0] y,
                                  input logic signed [13:0] w, input logic signed [13:0] h);
    in_win = (x >= 0) && (14'(x) < w) && (y >= 0) && (14'(y) < h);
  endfunction

  assign in_stall = job_stall;
  assign take = in_valid && !in_stall;

  always_comb begin
    dxl = (in_x_end > in_x_start) ? 14'(in_x_end) - 14'(in_x_start)
                                  : 14'(in_x_start) - 14'(in_x_end);
    dyl = (in_y_end > in_y_start) ? 14'(in_y_end) - 14'(in_y_start)
                                  : 14'(in_y_start) - 14'(in_y_end);
    maj = (dxl > dyl) ? dxl : -dyl;
    maj = (maj < 0) ? -((-maj) >>> 1) : (maj >>> 1);
    inside_ok = in_win(cur_x_r, cur_y_r, WW, WH) && in_win(stop_x_r, stop_y_r, WW, WH);
    xmajor = dx_r > dy_r;
    nerr = err_r;
    ncx = 14'(cur_x_r);
    ncy = 14'(cur_y_r);
    if (err_r > -dx_r) begin
      nerr = nerr - dy_r;
      ncx = sx_r ? ncx - 14'sd1 : ncx + 14'sd1;
    end
    if (err_r < dy_r) begin
      nerr = nerr + dx_r;
      ncy = sy_r ? ncy - 14'sd1 : ncy + 14'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      job_valid <= 1'b0;
    end else if (!job_stall) begin
      job_valid <= 1'b0;
      if (take && in_kind == glr_pkg::KIND_LOAD) begin
        active_r <= (in_x_start != in_x_end) || (in_y_start != in_y_end);
        cur_x_r <= in_x_start; org_x_r <= in_x_start;
        cur_y_r <= in_y_start; org_y_r <= in_y_start;
        stop_x_r <= in_x_end; stop_y_r <= in_y_end;
        c1_r <= in_color_start; c2_r <= in_color_end;
        dx_r <= dxl; dy_r <= dyl;
        sx_r <= !(in_x_start < in_x_end);
        sy_r <= !(in_y_start < in_y_end);
        err_r <= maj;
      end else if (take && active_r) begin
        job_valid <= 1'b1;
        job.c1 <= c1_r;
        job.c2 <= c2_r;
        job.px <= cur_x_r[10:0];
        job.py <= cur_y_r[10:0];
        job.num <= xmajor ? 13'(14'(cur_x_r) - 14'(org_x_r))
                          : 13'(14'(cur_y_r) - 14'(org_y_r));
        job.den <= xmajor ? 13'(14'(stop_x_r) - 14'(org_x_r))
                          : 13'(14'(stop_y_r) - 14'(org_y_r));
        if (!inside_ok) begin
          job.abort <= 1'b1;
          job.last <= 1'b1;
          active_r <= 1'b0;
        end else begin
          job.abort <= 1'b0;
          err_r <= nerr;
          cur_x_r <= ncx[11:0];
          cur_y_r <= ncy[11:0];
          job.last <= (ncx[11:0] == stop_x_r) && (ncy[11:0] == stop_y_r);
          if ((ncx[11:0] == stop_x_r) && (ncy[11:0] == stop_y_r)) active_r <= 1'b0;
        end
      end
    end
  end

  a_abort_last: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job.abort |-> job.last) else $error("abort without last");
  a_idle_after_abort: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(job_valid) && job.abort |-> !active_r) else $error("line active after abort");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(job_valid) && job.last |-> !active_r) else $error("line active after last");

endmodule

### rtl/glr_color.sv
// Back part: a queue stage feeding a pipelined per-channel divider for the color interpolation.
module glr_color (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_stall,
  input  glr_pkg::glr_job_t job,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_status,
  output logic [10:0]       out_pixel_x,
  output logic [10:0]       out_pixel_y,
  output logic [23:0]       out_pixel_color,
  output logic              out_last
);

  localparam int unsigned NB = 13;
  localparam int unsigned NS = NB + 2;

  // Two-entry queue between the stepper and the divider.
  logic [1:0]        q_cnt_r;
  logic              q_wp_r, q_rp_r;
  glr_pkg::glr_job_t q_mem_r [2];
  logic              q_push, q_pop, q_empty;
  glr_pkg::glr_job_t head;

  // Stage 0 forms |(c2-c1)*num| and |den|; NB restoring stages then divide.
  logic [NS-1:0]      v_r;
  logic [20:0]        rem_r [NS][3];
  logic [20:0]        quo_r [NS][3];
  logic               neg_r [NS][3];
  logic [12:0]        den_r [NS];
  logic [7:0]         a_r   [NS][3];
  logic               same_r[NS];
  logic               zero_r[NS];
  logic               ab_r  [NS];
  logic               ls_r  [NS];
  logic [10:0]        px_r  [NS];
  logic [10:0]        py_r  [NS];

  logic adv;
  assign adv = !(out_stall && v_r[NS-1]);

  assign q_empty   = q_cnt_r == 2'd0;
  assign job_stall = q_cnt_r == 2'd2;
  assign q_push    = job_valid && !job_stall;
  assign q_pop     = adv && !q_empty;
  assign head      = q_mem_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
    end else begin
      if (q_push) q_wp_r <= !q_wp_r;
      if (q_pop) q_rp_r <= !q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(q_push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) q_mem_r[q_wp_r] <= job;
  end

  assign out_valid  = v_r[NS-1];
  assign out_status = ab_r[NS-1] ? glr_pkg::STATUS_ABORT : glr_pkg::STATUS_PIXEL;
  assign out_last   = ls_r[NS-1];
  assign out_pixel_x = ab_r[NS-1] ? 11'd0 : px_r[NS-1];
  assign out_pixel_y = ab_r[NS-1] ? 11'd0 : py_r[NS-1];

  always_comb begin
    logic [7:0] ch [3];
    logic signed [9:0] q;
    for (int c = 0; c < 3; c++) begin
      q = neg_r[NS-1][c] ? -$signed({2'b0, quo_r[NS-1][c][7:0]})
                         : $signed({2'b0, quo_r[NS-1][c][7:0]});
      ch[c] = (same_r[NS-1] || zero_r[NS-1]) ? a_r[NS-1][c]
            : 8'(10'(a_r[NS-1][c]) + 10'(q));
    end
    out_pixel_color = ab_r[NS-1] ? 24'd0 : {ch[2], ch[1], ch[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-2:0], !q_empty};
  end

  always_ff @(posedge clk) begin
    logic signed [9:0]  diff;
    logic signed [22:0] prod;
    logic [25:0]        trial;
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        diff = $signed({2'b0, head.c2[8*c +: 8]}) - $signed({2'b0, head.c1[8*c +: 8]});
        prod = 23'(diff) * 23'($signed(head.num));
        neg_r[0][c] <= prod[22] ^ head.den[12];
        rem_r[0][c] <= 21'(prod[22] ? -prod : prod);
        quo_r[0][c] <= '0;
        a_r[0][c]   <= head.c1[8*c +: 8];
      end
      den_r[0]  <= head.den[12] ? -head.den : head.den;
      same_r[0] <= head.c1 == head.c2;
      zero_r[0] <= head.den == '0;
      ab_r[0] <= head.abort; ls_r[0] <= head.last;
      px_r[0] <= head.px; py_r[0] <= head.py;
      for (int s = 1; s < NS; s++) begin
        for (int c = 0; c < 3; c++) begin
          a_r[s][c] <= a_r[s-1][c];
          neg_r[s][c] <= neg_r[s-1][c];
          if (s <= NB) begin
            trial = {5'b0, rem_r[s-1][c]} - (26'(den_r[s-1]) << (NB - s));
            if (!trial[25]) begin
              rem_r[s][c] <= trial[20:0];
              quo_r[s][c] <= quo_r[s-1][c] | (21'd1 << (NB - s));
            end else begin
              rem_r[s][c] <= rem_r[s-1][c];
              quo_r[s][c] <= quo_r[s-1][c];
            end
          end else begin
            rem_r[s][c] <= rem_r[s-1][c];
            quo_r[s][c] <= quo_r[s-1][c];
          end
        end
        den_r[s] <= den_r[s-1]; same_r[s] <= same_r[s-1]; zero_r[s] <= zero_r[s-1];
        ab_r[s] <= ab_r[s-1]; ls_r[s] <= ls_r[s-1];
        px_r[s] <= px_r[s-1]; py_r[s] <= py_r[s-1];
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");
  a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == glr_pkg::STATUS_ABORT |-> out_last && out_pixel_color == 24'd0)
    else $error("bad abort result");
  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3) else $error("queue overflow");

endmodule

### rtl/gradient_line_rasterizer_top.sv
// Top level of the gradient line rasterizer.
// A load transfer sets up a line and gives no result; each step transfer on an active line gives
// one result, a pixel or an abort when either endpoint lies outside the window. One step is taken
// per clock unless the input is stalled; each result passes the stepper's job register, one slot
// of the two-entry queue, one setup and multiply stage, 13 quotient stages of the bit-per-stage
// color divider and one output stage. A stall on the result side holds the divider pipeline; the
// queue keeps taking jobs until it is full, and only then is the input stalled.
module gradient_line_rasterizer_top #(
  parameter int unsigned WIN_W = glr_pkg::WIN_W_DEF,
  parameter int unsigned WIN_H = glr_pkg::WIN_H_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic signed [11:0] in_x_start,
  input  logic signed [11:0] in_y_start,
  input  logic signed [11:0] in_x_end,
  input  logic signed [11:0] in_y_end,
  input  logic [23:0]        in_color_start,
  input  logic [23:0]        in_color_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic [10:0]        out_pixel_x,
  output logic [10:0]        out_pixel_y,
  output logic [23:0]        out_pixel_color,
  output logic               out_last
);

  logic              job_valid, job_stall;
  glr_pkg::glr_job_t job;

  glr_stepper #(.WIN_W(WIN_W), .WIN_H(WIN_H)) u_step (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_x_start, .in_y_start,
    .in_x_end, .in_y_end, .in_color_start, .in_color_end,
    .job_valid, .job_stall, .job
  );

  glr_color u_color (
    .clk, .rst_n, .job_valid, .job_stall, .job,
    .out_valid, .out_stall, .out_status, .out_pixel_x, .out_pixel_y,
    .out_pixel_color, .out_last
  );

endmodule
